// File: hw/rtl/cau_pkg.sv
// cau_pkg: shared types, widths and helpers for the complex arithmetic unit
// no dependencies
package cau_pkg;

   localparam int QFrac    = 8;
   localparam int OpWidth  = 16;
   localparam int CmdWidth = 2;
   localparam int DirWidth = 25;            // pre-clamp width of a result part
   localparam int MagWidth = 32;            // divide numerator magnitude
   localparam int DenWidth = 32;            // divisor magnitude b_re^2 + b_im^2
   localparam int QuoWidth = 16;            // quotient bits below overflow
   localparam int NumWidth = MagWidth + QFrac;
   localparam int CmpWidth = DenWidth + QuoWidth;
   localparam int DivStages = QuoWidth + 1;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // per-word control and non-divide results traveling beside the divider
   typedef struct packed {
      logic                       valid;
      cmd_type                    cmd;
      logic                       dz;
      logic signed [DirWidth-1:0] dir_re;
      logic signed [DirWidth-1:0] dir_im;
   } side_type;

   // clamp to signed 16 bits; msb of the result is the saturation flag
   function automatic logic [OpWidth:0] clamp16(input logic signed [DirWidth-1:0] v);
      logic [OpWidth:0] r;
      if (v > DirWidth'(32767)) begin
         r = {1'b1, 16'h7fff};
      end else if (v < -DirWidth'(32768)) begin
         r = {1'b1, 16'h8000};
      end else begin
         r = {1'b0, v[OpWidth-1:0]};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/cau_div_pipe.sv
// cau_div_pipe: two-lane pipelined restoring divider, one quotient bit per stage
// depends on cau_pkg
module cau_div_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [cau_pkg::MagWidth-1:0]    mag_re,
   input  logic [cau_pkg::MagWidth-1:0]    mag_im,
   input  logic [cau_pkg::DenWidth-1:0]    den,
   input  logic                            neg_re,
   input  logic                            neg_im,
   input  cau_pkg::side_type               side_in,
   output logic [cau_pkg::QuoWidth-1:0]    q_re,
   output logic [cau_pkg::QuoWidth-1:0]    q_im,
   output logic                            of_re,
   output logic                            of_im,
   output logic                            sign_re,
   output logic                            sign_im,
   output cau_pkg::side_type               side_out
);
   import cau_pkg::*;

   logic [NumWidth-1:0] n_re_ff [DivStages];
   logic [NumWidth-1:0] n_im_ff [DivStages];
   logic [QuoWidth-1:0] q_re_ff [DivStages];
   logic [QuoWidth-1:0] q_im_ff [DivStages];
   logic                of_re_ff [DivStages];
   logic                of_im_ff [DivStages];
   logic                neg_re_ff [DivStages];
   logic                neg_im_ff [DivStages];
   logic [DenWidth-1:0] den_ff [DivStages];
   side_type            side_ff [DivStages];
   logic                valid_ff [DivStages];

   logic [NumWidth-1:0] n0_re, n0_im;
   logic [CmpWidth-1:0] d_top;

   assign n0_re = {mag_re, QFrac'(0)};
   assign n0_im = {mag_im, QFrac'(0)};
   assign d_top = {den, QuoWidth'(0)};

   // stage 0: overflow check against den << 16
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= side_in.valid;
      end
      if (adv) begin
         n_re_ff[0]   <= n0_re;
         n_im_ff[0]   <= n0_im;
         q_re_ff[0]   <= '0;
         q_im_ff[0]   <= '0;
         of_re_ff[0]  <= CmpWidth'(n0_re) >= d_top;
         of_im_ff[0]  <= CmpWidth'(n0_im) >= d_top;
         neg_re_ff[0] <= neg_re;
         neg_im_ff[0] <= neg_im;
         den_ff[0]    <= den;
         side_ff[0]   <= side_in;
      end
   end

   // stages 1..16: quotient bit 16-k
   for (genvar k = 1; k < DivStages; k++) begin : g_step
      localparam int Sh = QuoWidth - k;
      logic [CmpWidth-1:0] dsh;
      logic                ge_re, ge_im;
      logic [NumWidth-1:0] n_re_in, n_im_in;

      assign dsh   = CmpWidth'(den_ff[k-1]) << Sh;
      assign ge_re = CmpWidth'(n_re_ff[k-1]) >= dsh;
      assign ge_im = CmpWidth'(n_im_ff[k-1]) >= dsh;
      assign n_re_in = ge_re ? NumWidth'(CmpWidth'(n_re_ff[k-1]) - dsh) : n_re_ff[k-1];
      assign n_im_in = ge_im ? NumWidth'(CmpWidth'(n_im_ff[k-1]) - dsh) : n_im_ff[k-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (adv) begin
            n_re_ff[k]       <= n_re_in;
            n_im_ff[k]       <= n_im_in;
            q_re_ff[k]       <= q_re_ff[k-1] | (QuoWidth'(ge_re) << Sh);
            q_im_ff[k]       <= q_im_ff[k-1] | (QuoWidth'(ge_im) << Sh);
            of_re_ff[k]      <= of_re_ff[k-1];
            of_im_ff[k]      <= of_im_ff[k-1];
            neg_re_ff[k]     <= neg_re_ff[k-1];
            neg_im_ff[k]     <= neg_im_ff[k-1];
            den_ff[k]        <= den_ff[k-1];
            side_ff[k]       <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      side_out       = side_ff[DivStages-1];
      side_out.valid = valid_ff[DivStages-1];
   end
   assign q_re    = q_re_ff[DivStages-1];
   assign q_im    = q_im_ff[DivStages-1];
   assign of_re   = of_re_ff[DivStages-1];
   assign of_im   = of_im_ff[DivStages-1];
   assign sign_re = neg_re_ff[DivStages-1];
   assign sign_im = neg_im_ff[DivStages-1];

   // valid bit moves one stage per advance
   a_valid_side: assert property (@(posedge clock) disable iff (reset)
      adv |=> valid_ff[1] == $past(valid_ff[0]))
      else $error("divider valid did not move with stage");

   // a frozen pipe keeps its last valid bit
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff[DivStages-1]))
      else $error("divider valid changed while frozen");

   // a valid word leaves with a fully resolved quotient
   a_quo_known: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DivStages-1] |-> !$isunknown({q_re_ff[DivStages-1], q_im_ff[DivStages-1]}))
      else $error("divider quotient unknown on a valid word");

endmodule

// File: hw/rtl/complex_arith_unit.sv
// complex_arith_unit: pipelined complex add/sub/mul/div on signed Q8.8 operands
// depends on cau_pkg and cau_div_pipe
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid, req_stall, req_cmd, req_a_re/a_im,  | in
//          | req_b_re, req_b_im                             |
//  rsp     | rsp_valid, rsp_stall, rsp_res_re, rsp_res_im,  | out
//          | rsp_saturated, rsp_divide_by_zero              |
//
// one word accepted per clock while the output is not stalled; one result word
// per input word, in order; stages: product, combine, 17 divider stages, output
// register; every opcode takes the same path so order is kept
// the divider's 16-bit quotient plus overflow stage sets the pipeline depth
// reset (synchronous) clears all valid bits; payload registers are not reset
// a stalled output word freezes the whole pipeline; req_stall rises only then
module complex_arith_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cau_pkg::CmdWidth-1:0]  req_cmd,
   input  logic signed [cau_pkg::OpWidth-1:0] req_a_re,
   input  logic signed [cau_pkg::OpWidth-1:0] req_a_im,
   input  logic signed [cau_pkg::OpWidth-1:0] req_b_re,
   input  logic signed [cau_pkg::OpWidth-1:0] req_b_im,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [cau_pkg::OpWidth-1:0] rsp_res_re,
   output logic signed [cau_pkg::OpWidth-1:0] rsp_res_im,
   output logic                          rsp_saturated,
   output logic                          rsp_divide_by_zero
);
   import cau_pkg::*;

   localparam int PWidth = 2 * OpWidth;     // one 16x16 product
   localparam int SWidth = PWidth + 1;      // sum of two products

   // global advance: pipeline moves unless the output word is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- stage 1: products and plain sums ----------------
   logic                       s1_valid_ff;
   cmd_type                    s1_cmd_ff;
   logic signed [PWidth-1:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [OpWidth:0]    sum_re_ff, sum_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         s1_cmd_ff <= cmd_type'(req_cmd);
         p_rr_ff   <= req_a_re * req_b_re;
         p_ii_ff   <= req_a_im * req_b_im;
         p_ri_ff   <= req_a_re * req_b_im;
         p_ir_ff   <= req_a_im * req_b_re;
         p_bb_ff   <= req_b_re * req_b_re;
         p_cc_ff   <= req_b_im * req_b_im;
         // add and subtract share the adder via the opcode
         if (cmd_type'(req_cmd) == CMD_SUB) begin
            sum_re_ff <= (OpWidth+1)'(req_a_re) - (OpWidth+1)'(req_b_re);
            sum_im_ff <= (OpWidth+1)'(req_a_im) - (OpWidth+1)'(req_b_im);
         end else begin
            sum_re_ff <= (OpWidth+1)'(req_a_re) + (OpWidth+1)'(req_b_re);
            sum_im_ff <= (OpWidth+1)'(req_a_im) + (OpWidth+1)'(req_b_im);
         end
      end
   end

   // ---------------- stage 2: combine products ----------------
   logic signed [SWidth-1:0] mul_re, mul_im, num_re, num_im;
   logic [DenWidth-1:0]      den_in;
   side_type                 s2_side_in;

   assign mul_re = SWidth'(p_rr_ff) - SWidth'(p_ii_ff);
   assign mul_im = SWidth'(p_ri_ff) + SWidth'(p_ir_ff);
   assign num_re = SWidth'(p_rr_ff) + SWidth'(p_ii_ff);
   assign num_im = SWidth'(p_ir_ff) - SWidth'(p_ri_ff);
   // squares are never negative, so the unsigned sum fits 32 bits
   assign den_in = DenWidth'(p_bb_ff) + DenWidth'(p_cc_ff);

   always_comb begin
      s2_side_in.valid = s1_valid_ff;
      s2_side_in.cmd   = s1_cmd_ff;
      s2_side_in.dz    = (s1_cmd_ff == CMD_DIV) && (den_in == '0);
      case (s1_cmd_ff)
         CMD_MUL: begin
            // floor shift of the Q17.16 sum back to Q8.8
            s2_side_in.dir_re = DirWidth'(mul_re >>> QFrac);
            s2_side_in.dir_im = DirWidth'(mul_im >>> QFrac);
         end
         default: begin
            s2_side_in.dir_re = DirWidth'(sum_re_ff);
            s2_side_in.dir_im = DirWidth'(sum_im_ff);
         end
      endcase
   end

   logic                s2_valid_ff;
   side_type            s2_side_ff;
   logic [MagWidth-1:0] mag_re_ff, mag_im_ff;
   logic                neg_re_ff, neg_im_ff;
   logic [DenWidth-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_side_ff <= s2_side_in;
         neg_re_ff  <= num_re[SWidth-1];
         neg_im_ff  <= num_im[SWidth-1];
         mag_re_ff  <= num_re[SWidth-1] ? MagWidth'(-num_re) : MagWidth'(num_re);
         mag_im_ff  <= num_im[SWidth-1] ? MagWidth'(-num_im) : MagWidth'(num_im);
         den_ff     <= den_in;
      end
   end

   side_type s2_side;
   always_comb begin
      s2_side       = s2_side_ff;
      s2_side.valid = s2_valid_ff;
   end

   // ---------------- divider stages ----------------
   logic [QuoWidth-1:0] q_re, q_im;
   logic                of_re, of_im, sign_re, sign_im;
   side_type            div_side;

   cau_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .mag_re   (mag_re_ff),
      .mag_im   (mag_im_ff),
      .den      (den_ff),
      .neg_re   (neg_re_ff),
      .neg_im   (neg_im_ff),
      .side_in  (s2_side),
      .q_re     (q_re),
      .q_im     (q_im),
      .of_re    (of_re),
      .of_im    (of_im),
      .sign_re  (sign_re),
      .sign_im  (sign_im),
      .side_out (div_side)
   );

   // ---------------- final select and clamp ----------------
   logic signed [DirWidth-1:0] pre_re, pre_im, qv_re, qv_im;
   logic [OpWidth:0]           cl_re, cl_im;
   logic signed [OpWidth-1:0]  res_re_in, res_im_in;
   logic                       sat_in;

   // overflow forces a magnitude of 2^16, which always clamps
   assign qv_re = of_re ? DirWidth'(1 << QuoWidth) : DirWidth'(q_re);
   assign qv_im = of_im ? DirWidth'(1 << QuoWidth) : DirWidth'(q_im);

   always_comb begin
      if (div_side.cmd == CMD_DIV) begin
         pre_re = sign_re ? -qv_re : qv_re;
         pre_im = sign_im ? -qv_im : qv_im;
      end else begin
         pre_re = div_side.dir_re;
         pre_im = div_side.dir_im;
      end
      cl_re = clamp16(pre_re);
      cl_im = clamp16(pre_im);
      if (div_side.dz) begin
         // zero divisor: both parts zero, no clamp flag
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
      end else begin
         res_re_in = cl_re[OpWidth-1:0];
         res_im_in = cl_im[OpWidth-1:0];
         sat_in    = cl_re[OpWidth] | cl_im[OpWidth];
      end
   end

   logic                      rsp_valid_ff;
   logic signed [OpWidth-1:0] res_re_ff, res_im_ff;
   logic                      sat_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_side.valid;
      end
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         sat_ff    <= sat_in;
         dz_ff     <= div_side.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_re         = res_re_ff;
   assign rsp_res_im         = res_im_ff;
   assign rsp_saturated      = sat_ff;
   assign rsp_divide_by_zero = dz_ff;

   // zero divisor words carry a clean zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         rsp_res_re == '0 && rsp_res_im == '0 && !rsp_saturated)
      else $error("divide by zero word has nonzero payload");

   // a clamp flag means one part sits at a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_res_re == 16'sh7fff || rsp_res_re == -16'sh8000 ||
         rsp_res_im == 16'sh7fff || rsp_res_im == -16'sh8000)
      else $error("saturation flag without a clamped part");

   // input is held off only while a result word is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // a held output word does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im))
      else $error("output word changed under stall");

endmodule

// File: dv/complex_arith_unit_tb.sv
// complex_arith_unit_tb: self-checking testbench for the complex arithmetic unit
// depends on cau_pkg and the complex_arith_unit rtl
// drives operand words through the valid/stall channels and scores every result

// scoreboard: predicts each result from its input word and checks in order
class cau_scoreboard;
   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               sat;
      logic               dz;
   } result_t;

   result_t pending_results[$];
   int      errors;

   function automatic logic signed [15:0] clamp(longint v, ref logic sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return -16'sh8000;
      end
      return v[15:0];
   endfunction

   // floor division by 256
   function automatic longint floor_q(longint v);
      return v >>> 8;
   endfunction

   function void note_input(cau_pkg::cmd_type cmd, logic signed [15:0] ar,
                            logic signed [15:0] ai, logic signed [15:0] br,
                            logic signed [15:0] bi);
      longint  xr, xi, yr, yi, rr, ri, den;
      result_t r;
      xr = ar;
      xi = ai;
      yr = br;
      yi = bi;
      rr = 0;
      ri = 0;
      r.sat = 1'b0;
      r.dz = 1'b0;
      case (cmd)
         cau_pkg::CMD_ADD: begin
            rr = xr + yr;
            ri = xi + yi;
         end
         cau_pkg::CMD_SUB: begin
            rr = xr - yr;
            ri = xi - yi;
         end
         cau_pkg::CMD_MUL: begin
            rr = floor_q(xr * yr - xi * yi);
            ri = floor_q(xr * yi + xi * yr);
         end
         default: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               // longint division truncates toward zero
               rr = ((xr * yr + xi * yi) * 256) / den;
               ri = ((xi * yr - xr * yi) * 256) / den;
            end
         end
      endcase
      r.re = clamp(rr, r.sat);
      r.im = clamp(ri, r.sat);
      pending_results.push_back(r);
   endfunction

   function void check_result(logic signed [15:0] re, logic signed [15:0] im,
                              logic sat, logic dz);
      result_t e;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result re=%0d im=%0d", $time, re, im);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      if (re !== e.re) begin
         $display("%0t: res_re expected %0d actual %0d", $time, e.re, re);
         errors++;
      end
      if (im !== e.im) begin
         $display("%0t: res_im expected %0d actual %0d", $time, e.im, im);
         errors++;
      end
      if (sat !== e.sat) begin
         $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
         errors++;
      end
      if (dz !== e.dz) begin
         $display("%0t: divide_by_zero expected %0b actual %0b", $time, e.dz, dz);
         errors++;
      end
   endfunction
endclass

module complex_arith_unit_tb;
   import cau_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = '0;
   logic signed [15:0] req_a_re = '0;
   logic signed [15:0] req_a_im = '0;
   logic signed [15:0] req_b_re = '0;
   logic signed [15:0] req_b_im = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_res_re;
   logic signed [15:0] rsp_res_im;
   logic               rsp_saturated;
   logic               rsp_divide_by_zero;

   cau_scoreboard scoreboard = new();

   // idle percentages per side, changed by phase
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  pressure_on = 1'b0;    // start of the no-idle phase
   bit  hold_off = 1'b0;       // receiver long stall request
   bit  stimulus_done = 1'b0;
   int  results_seen = 0;

   complex_arith_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_a_re           (req_a_re),
      .req_a_im           (req_a_im),
      .req_b_re           (req_b_re),
      .req_b_im           (req_b_im),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_res_re         (rsp_res_re),
      .rsp_res_im         (rsp_res_im),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // offer one word, with a random idle gap first; returns once accepted
   task automatic send_word(cmd_type cmd, logic [15:0] ar, logic [15:0] ai,
                            logic [15:0] br, logic [15:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_a_re  <= ar;
      req_a_im  <= ai;
      req_b_re  <= br;
      req_b_im  <= bi;
      // wait for the accepting edge
      do @(posedge clock); while (req_stall);
      scoreboard.note_input(cmd, ar, ai, br, bi);
   endtask

   // random operand: mostly full range, sometimes an extreme or a small value
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(9))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'($signed($urandom_range(1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(int count);
      logic [15:0] br, bi;
      repeat (count) begin
         br = pick_operand();
         bi = pick_operand();
         // give the zero divisor a fair chance
         if ($urandom_range(19) == 0) begin
            br = '0;
            bi = '0;
         end
         send_word(cmd_type'($urandom_range(3)), pick_operand(), pick_operand(), br, bi);
      end
   endtask

   // receiver stall: random per cycle, or held high while hold_off is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result monitor: a word moves when valid is high and stall is low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_result(rsp_res_re, rsp_res_im, rsp_saturated,
                                 rsp_divide_by_zero);
         results_seen++;
      end
   end

   // long hold-off counted here while the sender keeps offering words
   initial begin
      wait (pressure_on);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (80) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int c;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every opcode against the extremes and one moderate operand set
      for (c = 0; c < 4; c++) begin
         send_word(cmd_type'(c), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
         send_word(cmd_type'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         send_word(cmd_type'(c), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
         send_word(cmd_type'(c), 16'h0100, 16'hff00, 16'h0200, 16'h0080);
      end
      // zero divisor, with and without a zero dividend
      send_word(CMD_DIV, 16'h1234, 16'hfedc, 16'h0000, 16'h0000);
      send_word(CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // tiny divisor forces quotient saturation
      send_word(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      // negative product floors; negative quotient truncates toward zero
      send_word(CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
      send_word(CMD_DIV, 16'hffff, 16'h0000, 16'h0300, 16'h0000);

      // sender idles 20, receiver 70
      send_idle_pct = 20;
      recv_idle_pct = 70;
      send_random(200);
      // the other way round
      send_idle_pct = 70;
      recv_idle_pct = 20;
      send_random(200);
      // no idling; the hold-off fills the pipe while the sender pushes
      recv_idle_pct = 0;
      send_idle_pct = 0;
      pressure_on = 1'b1;
      send_random(230);
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered all four opcodes, operand extremes, zero divisor and");
      $display("saturation under stalls on both sides; %0d results checked",
               results_seen);
      if (scoreboard.errors == 0 && scoreboard.pending_results.size() == 0) begin
         $display("complex_arith_unit_tb: PASS");
      end else begin
         $display("complex_arith_unit_tb: FAIL");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #2000000;
      $display("complex_arith_unit_tb: FAIL");
      $finish;
   end
endmodule
